/* rtl/ascii_decimal_token_parser_top_assert.svh */
// ----------------------------------------------------------------------------
// ascii_decimal_token_parser_top_assert.svh
// Assertion macros for the token parser; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASCII_DECIMAL_TOKEN_PARSER_TOP_ASSERT_SVH
`define ASCII_DECIMAL_TOKEN_PARSER_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define ADTP_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("adtp assertion failed");
`define ADTP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("adtp assertion failed");
`else
`define ADTP_ASSERT(label, prop)
`define ADTP_ASSERT_NEXT(label, ante, cons)
`endif
`endif

/* rtl/adtp_pkg.sv */
// ----------------------------------------------------------------------------
// adtp_pkg
// Types and constants shared by the decimal token parser.
// ----------------------------------------------------------------------------
package adtp_pkg;

  localparam int unsigned QueueDepth = 2;

  localparam logic [7:0] CH_SEP_MAX = 8'd32;
  localparam logic [7:0] CH_ZERO    = 8'd48;
  localparam logic [7:0] CH_MINUS   = 8'd45;
  localparam logic [7:0] CH_POINT   = 8'd46;

  localparam logic [1:0] KIND_UNSIGNED = 2'd0;
  localparam logic [1:0] KIND_SIGNED   = 2'd1;
  localparam logic [1:0] KIND_REAL     = 2'd2;
  localparam logic [1:0] KIND_SKIP     = 2'd3;

  localparam logic [3:0] FRAC_MAX = 4'd15;

  typedef struct packed {
    logic [7:0] ch;
    logic [1:0] func;
  } adtp_in_t;

  typedef struct packed {
    logic signed [47:0] value;
    logic [3:0]         frac_digits;
    logic [1:0]         kind;
    logic               overflow;
  } adtp_out_t;

  // classified byte
  typedef struct packed {
    logic       sep;
    logic       is_digit;
    logic       is_minus;
    logic       is_point;
    logic [7:0] digit;
    logic [1:0] func;
  } adtp_item_t;

endpackage

/* rtl/ascii_decimal_token_parser_top.sv */
// ----------------------------------------------------------------------------
// ascii_decimal_token_parser_top
// The byte that ends a token is registered in the queue; its result is then
// registered in the result register. Throughput: one byte per cycle while not
// stalled; the accumulator does one x10-plus-digit step per cycle, and a 2-word
// queue decouples input from the result register. Reset: asynchronous, active
// low; parser returns to between-tokens, queue and result register empty.
// ----------------------------------------------------------------------------
module ascii_decimal_token_parser_top import adtp_pkg::*; #(
  parameter int unsigned MANTISSA_WIDTH = 48
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  adtp_in_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output adtp_out_t out_data_o
);

  localparam int unsigned AccW = (MANTISSA_WIDTH > 48) ? 48 : MANTISSA_WIDTH;

  logic       q_full;
  logic       q_push;
  adtp_item_t q_push_item;
  logic       q_valid;
  logic       q_pop;
  adtp_item_t q_pop_item;

  adtp_front u_front (
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_item_o   (q_push_item)
  );

  adtp_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_item_i (q_push_item),
    .full_o      (q_full),
    .valid_o     (q_valid),
    .pop_i       (q_pop),
    .pop_item_o  (q_pop_item)
  );

  adtp_back #(
    .ACC_W (AccW)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (q_valid),
    .item_i       (q_pop_item),
    .item_pop_o   (q_pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_data_o   (out_data_o)
  );

endmodule

/* rtl/adtp_front.sv */
// ----------------------------------------------------------------------------
// adtp_front
// Input side: takes text bytes and classifies them for the queue.
// ----------------------------------------------------------------------------
module adtp_front import adtp_pkg::*; (
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  adtp_in_t   in_data_i,
  input  logic       q_full_i,
  output logic       q_push_o,
  output adtp_item_t q_item_o
);

  assign in_stall_o = q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i;

  always_comb begin
    q_item_o.sep      = (in_data_i.ch <= CH_SEP_MAX);
    q_item_o.is_digit = (in_data_i.ch >= CH_ZERO);
    q_item_o.is_minus = (in_data_i.ch == CH_MINUS);
    q_item_o.is_point = (in_data_i.ch == CH_POINT);
    q_item_o.digit    = in_data_i.ch - CH_ZERO;
    q_item_o.func     = in_data_i.func;
  end

endmodule

/* rtl/adtp_queue.sv */
// ----------------------------------------------------------------------------
// adtp_queue
// Short word queue between front and back.
// ----------------------------------------------------------------------------
`include "ascii_decimal_token_parser_top_assert.svh"

module adtp_queue import adtp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  adtp_item_t push_item_i,
  output logic       full_o,
  output logic       valid_o,
  input  logic       pop_i,
  output adtp_item_t pop_item_o
);

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(QueueDepth - 1);
  localparam logic [CntW-1:0] DepthCnt = CntW'(QueueDepth);

  adtp_item_t            entries_q [QueueDepth];
  logic [PtrW-1:0]       wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]       rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]       cnt_q, cnt_d;

  assign full_o     = (cnt_q == DepthCnt);
  assign valid_o    = (cnt_q != '0);
  assign pop_item_o = entries_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wr_ptr_q] <= push_item_i;
    end
  end

  `ADTP_ASSERT(q_cnt_bound, cnt_q <= DepthCnt)
  `ADTP_ASSERT_NEXT(q_cnt_up, push_i && !pop_i, cnt_q == $past(cnt_q) + 1'b1)
  `ADTP_ASSERT_NEXT(q_cnt_down, pop_i && !push_i, cnt_q == $past(cnt_q) - 1'b1)

endmodule

/* rtl/adtp_back.sv */
// ----------------------------------------------------------------------------
// adtp_back
// Token state machine: accumulates digits and registers one result per non-skip token.
// ----------------------------------------------------------------------------
`include "ascii_decimal_token_parser_top_assert.svh"

module adtp_back import adtp_pkg::*; #(
  parameter int unsigned ACC_W = 48
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       item_valid_i,
  input  adtp_item_t item_i,
  output logic       item_pop_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output adtp_out_t  out_data_o
);

  typedef enum logic [1:0] {PH_IDLE, PH_INT, PH_FRAC, PH_SKIP} phase_e;

  localparam int unsigned ProdW = ACC_W + 4;
  localparam logic [ACC_W-1:0] MagLimit = {1'b0, {(ACC_W-1){1'b1}}};

  phase_e           phase_q, phase_d;
  logic [ACC_W-1:0] acc_q, acc_d;
  logic             neg_q, neg_d;
  logic [3:0]       frac_q, frac_d;
  logic [1:0]       kind_q, kind_d;
  logic             sat_q, sat_d;
  logic             out_valid_q, out_valid_d;
  adtp_out_t        out_q, out_d;

  logic             pop;
  logic             start;
  logic [ACC_W-1:0] acc_base;
  logic [ProdW-1:0] prod;
  logic [31:0]      int32;
  logic [47:0]      real_val;

  assign pop        = item_valid_i && (!out_valid_q || !out_stall_i);
  assign item_pop_o = pop;
  assign start      = (phase_q == PH_IDLE) && !item_i.sep;
  assign acc_base   = start ? '0 : acc_q;
  // acc * 10 + digit
  assign prod = ({4'b0, acc_base} << 3) + ({4'b0, acc_base} << 1) + ProdW'(item_i.digit);

  always_comb begin
    logic go;
    logic fire;
    go          = 1'b0;
    fire        = 1'b0;
    phase_d     = phase_q;
    acc_d       = acc_q;
    neg_d       = neg_q;
    frac_d      = frac_q;
    kind_d      = kind_q;
    sat_d       = sat_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    int32       = '0;
    real_val    = '0;

    if (pop) begin
      case (phase_q)
        PH_SKIP: begin
          if (item_i.sep) begin
            phase_d = PH_IDLE;
          end
        end
        PH_IDLE: begin
          if (!item_i.sep) begin
            kind_d = item_i.func;
            acc_d  = '0;
            neg_d  = 1'b0;
            frac_d = '0;
            sat_d  = 1'b0;
            if (item_i.func == KIND_SKIP) begin
              phase_d = PH_SKIP;
            end else begin
              phase_d = PH_INT;
              if (item_i.func != KIND_UNSIGNED && item_i.is_minus) begin
                neg_d = 1'b1;
              end else begin
                go = 1'b1;
              end
            end
          end
        end
        PH_INT:  go = 1'b1;
        PH_FRAC: go = 1'b1;
        default: go = 1'b1;
      endcase

      if (go) begin
        if (item_i.is_digit) begin
          if (kind_d == KIND_REAL) begin
            if (phase_d == PH_FRAC && frac_d == FRAC_MAX) begin
              sat_d = 1'b1;
            end else begin
              if (phase_d == PH_FRAC) begin
                frac_d = frac_d + 4'd1;
              end
              if (prod > {4'b0, MagLimit}) begin
                acc_d = MagLimit;
                sat_d = 1'b1;
              end else begin
                acc_d = prod[ACC_W-1:0];
              end
            end
          end else begin
            acc_d = ACC_W'(prod[31:0]);
          end
        end else if (item_i.is_point && kind_d == KIND_REAL && phase_d == PH_INT) begin
          phase_d = PH_FRAC;
        end else begin
          fire    = 1'b1;
          phase_d = PH_IDLE;
        end
      end
    end

    if (fire) begin
      out_valid_d = 1'b1;
      out_d.kind  = kind_d;
      if (kind_d == KIND_REAL) begin
        real_val          = neg_d ? (48'd0 - 48'(acc_d)) : 48'(acc_d);
        out_d.value       = real_val;
        out_d.frac_digits = frac_d;
        out_d.overflow    = sat_d;
      end else begin
        int32 = acc_d[31:0];
        if (kind_d == KIND_SIGNED && neg_d) begin
          int32 = 32'd0 - int32;
        end
        if (kind_d == KIND_SIGNED) begin
          out_d.value = {{16{int32[31]}}, int32};
        end else begin
          out_d.value = {16'd0, int32};
        end
        out_d.frac_digits = '0;
        out_d.overflow    = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      acc_q       <= '0;
      neg_q       <= 1'b0;
      frac_q      <= '0;
      kind_q      <= KIND_UNSIGNED;
      sat_q       <= 1'b0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      phase_q     <= phase_d;
      acc_q       <= acc_d;
      neg_q       <= neg_d;
      frac_q      <= frac_d;
      kind_q      <= kind_d;
      sat_q       <= sat_d;
      out_valid_q <= out_valid_d;
      out_q       <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `ADTP_ASSERT(bk_real_limit, (kind_q == KIND_REAL && (phase_q == PH_INT || phase_q == PH_FRAC)) |-> (acc_q <= MagLimit))
  `ADTP_ASSERT(bk_int_wrap, (kind_q != KIND_REAL && (phase_q == PH_INT || phase_q == PH_FRAC)) |-> (acc_q[ACC_W-1:32] == '0 && frac_q == '0))
  `ADTP_ASSERT(bk_out_kind, out_valid_q |-> (out_q.kind != KIND_SKIP))

endmodule

/* bench/tb_ascii_decimal_token_parser_top.sv */
// ----------------------------------------------------------------------------
// tb_ascii_decimal_token_parser_top
// Self-checking bench for the decimal token parser. Text bytes are streamed in
// with bursty valid, results are drained under a changing stall pattern, and
// every result word is compared against a cycle-free model of the parser.
// ----------------------------------------------------------------------------
module tb_ascii_decimal_token_parser_top import adtp_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MantW    = 48;
  localparam int unsigned EffW     = (MantW > 48) ? 48 : MantW;
  localparam bit [63:0]   MagLimit = (64'd1 << (EffW - 1)) - 64'd1;
  localparam bit [63:0]   Mask32   = 64'hFFFF_FFFF;
  localparam int unsigned RandBytes = 600;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_INT  = 2'd1,
    PH_FRAC = 2'd2,
    PH_SKIP = 2'd3
  } parse_phase_e;

  class token_scoreboard;
    parse_phase_e phase;
    bit [63:0]    mag;
    bit           neg;
    logic [3:0]   frac_cnt;
    logic [1:0]   tok_kind;
    bit           sat;
    adtp_out_t    token_q[$];
    int unsigned  errors;
    int unsigned  n_results;
    int unsigned  n_overflow;
    int unsigned  n_kind[3];

    function new();
      phase      = PH_IDLE;
      mag        = '0;
      neg        = 1'b0;
      frac_cnt   = '0;
      tok_kind   = KIND_UNSIGNED;
      sat        = 1'b0;
      errors     = 0;
      n_results  = 0;
      n_overflow = 0;
      foreach (n_kind[i]) n_kind[i] = 0;
    endfunction

    function void add_digit(bit [63:0] d);
      if (tok_kind == KIND_REAL) begin
        if (phase == PH_FRAC) begin
          if (frac_cnt >= FRAC_MAX) begin
            sat = 1'b1;
            return;
          end
          frac_cnt++;
        end
        if (mag > (MagLimit - d) / 64'd10) begin
          mag = MagLimit;
          sat = 1'b1;
        end else begin
          mag = mag * 64'd10 + d;
        end
      end else begin
        mag = (mag * 64'd10 + d) & Mask32;
      end
    endfunction

    function void close_token();
      bit [63:0] v;
      adtp_out_t r;
      r = '0;
      if (tok_kind == KIND_REAL) begin
        v = neg ? (64'd0 - mag) : mag;
        r.frac_digits = frac_cnt;
        r.overflow    = sat;
      end else begin
        v = mag & Mask32;
        if (tok_kind == KIND_SIGNED) begin
          if (neg) v = (64'd0 - v) & Mask32;
          if (v[31]) v = v | 64'h0000_FFFF_0000_0000;
        end
      end
      r.value = v[47:0];
      r.kind  = tok_kind;
      token_q.push_back(r);
    endfunction

    // one accepted input word
    function void note_word(adtp_in_t w);
      if (phase == PH_SKIP) begin
        if (w.ch <= CH_SEP_MAX) phase = PH_IDLE;
        return;
      end
      if (phase == PH_IDLE) begin
        if (w.ch <= CH_SEP_MAX) return;
        tok_kind = w.func;
        mag      = '0;
        neg      = 1'b0;
        frac_cnt = '0;
        sat      = 1'b0;
        if (w.func == KIND_SKIP) begin
          phase = PH_SKIP;
          return;
        end
        phase = PH_INT;
        if (w.func != KIND_UNSIGNED && w.ch == CH_MINUS) begin
          neg = 1'b1;
          return;
        end
      end
      if (w.ch >= CH_ZERO) begin
        add_digit(64'(w.ch - CH_ZERO));
        return;
      end
      if (w.ch == CH_POINT && tok_kind == KIND_REAL && phase == PH_INT) begin
        phase = PH_FRAC;
        return;
      end
      close_token();
      phase = PH_IDLE;
    endfunction

    // one accepted result word
    function void check_word(adtp_out_t got);
      adtp_out_t exp_w;
      if (token_q.size() == 0) begin
        $display("%0t: unexpected result value=%0d frac=%0d kind=%0d ovf=%0d",
                 $time, got.value, got.frac_digits, got.kind, got.overflow);
        errors++;
        return;
      end
      exp_w = token_q.pop_front();
      n_results++;
      if (exp_w.kind <= KIND_REAL) n_kind[exp_w.kind]++;
      if (exp_w.overflow) n_overflow++;
      if (got.value !== exp_w.value) begin
        $display("%0t: value mismatch: expected %0d actual %0d",
                 $time, exp_w.value, got.value);
        errors++;
      end
      if (got.frac_digits !== exp_w.frac_digits) begin
        $display("%0t: frac_digits mismatch: expected %0d actual %0d",
                 $time, exp_w.frac_digits, got.frac_digits);
        errors++;
      end
      if (got.kind !== exp_w.kind) begin
        $display("%0t: kind mismatch: expected %0d actual %0d",
                 $time, exp_w.kind, got.kind);
        errors++;
      end
      if (got.overflow !== exp_w.overflow) begin
        $display("%0t: overflow mismatch: expected %0d actual %0d",
                 $time, exp_w.overflow, got.overflow);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return token_q.size();
    endfunction
  endclass

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_stall_o;
  adtp_in_t  in_data_i;
  logic      out_valid_o;
  logic      out_stall_i;
  adtp_out_t out_data_o;

  token_scoreboard sb;
  int unsigned     sent_bytes;
  int unsigned     burst_left;
  int unsigned     stall_left;
  int unsigned     stall_mode;
  int unsigned     stall_cyc;

  ascii_decimal_token_parser_top #(
    .MANTISSA_WIDTH(MantW)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) sb.note_word(in_data_i);
      if (out_valid_o && !out_stall_i) sb.check_word(out_data_o);
    end
  end

  // receiver stall pattern
  always @(negedge clk_i) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(5, 60);
    end
    stall_left--;
    stall_cyc++;
    case (stall_mode)
      0: begin
        out_stall_i <= 1'b0;
      end
      1: begin
        out_stall_i <= 1'($urandom_range(0, 1));
      end
      2: begin
        out_stall_i <= ($urandom_range(0, 9) < 8);
      end
      default: begin
        out_stall_i <= (stall_cyc % 3 == 0);
      end
    endcase
  end

  function automatic logic [1:0] rand_func();
    return 2'($urandom_range(0, 3));
  endfunction

  function automatic logic [7:0] rand_digit();
    if ($urandom_range(0, 9) < 9) return CH_ZERO + 8'($urandom_range(0, 9));
    return 8'($urandom_range(48, 255));
  endfunction

  task automatic send_byte(input logic [7:0] ch, input logic [1:0] fn);
    int unsigned gap;
    in_data_i  <= '{ch: ch, func: fn};
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    sent_bytes++;
    @(negedge clk_i);
    if (burst_left == 0) begin
      if ($urandom_range(0, 3) == 0) begin
        burst_left = $urandom_range(30, 80);
        gap        = $urandom_range(0, 1);
      end else begin
        burst_left = $urandom_range(1, 12);
        gap        = $urandom_range(1, 8);
      end
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end else begin
      burst_left--;
    end
  endtask

  task automatic send_str(input string s, input logic [1:0] fn);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], (i == 0) ? fn : rand_func());
  endtask

  // hold off the sender until every expected word is out
  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic send_random_token();
    logic [1:0]  fn;
    bit          lead;
    int unsigned n_int;
    int unsigned n_frac;
    fn   = rand_func();
    lead = 1'b1;
    if ($urandom_range(0, 9) < 2) begin
      repeat ($urandom_range(1, 8)) send_byte(8'($urandom_range(0, 255)), rand_func());
      return;
    end
    if (fn != KIND_UNSIGNED && $urandom_range(0, 1)) begin
      send_byte(CH_MINUS, fn);
      lead = 1'b0;
    end
    n_int = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 10) : $urandom_range(11, 20);
    repeat (n_int) begin
      send_byte(rand_digit(), lead ? fn : rand_func());
      lead = 1'b0;
    end
    if (fn == KIND_REAL && $urandom_range(0, 9) < 6) begin
      send_byte(CH_POINT, lead ? fn : rand_func());
      lead   = 1'b0;
      n_frac = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 8) : $urandom_range(14, 19);
      repeat (n_frac) send_byte(rand_digit(), rand_func());
    end
    if ($urandom_range(0, 3) != 0) begin
      send_byte(8'($urandom_range(0, 32)), lead ? fn : rand_func());
    end else begin
      send_byte(8'($urandom_range(33, 47)), lead ? fn : rand_func());
    end
    repeat ($urandom_range(0, 2)) send_byte(8'($urandom_range(0, 32)), rand_func());
  endtask

  initial begin
    int unsigned rand_start;
    bit          paused;
    sb          = new();
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    out_stall_i = 1'b0;
    sent_bytes  = 0;
    burst_left  = 0;
    stall_left  = 0;
    stall_mode  = 0;
    stall_cyc   = 0;
    paused      = 1'b0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    send_byte(CH_ZERO, KIND_UNSIGNED);
    send_byte(CH_SEP_MAX, rand_func());
    send_byte(8'd255, KIND_UNSIGNED);
    send_byte(8'd0, rand_func());
    send_byte(CH_MINUS, KIND_UNSIGNED);   // minus ends an unsigned token at once
    send_str("-9,", KIND_SIGNED);
    send_byte(CH_MINUS, KIND_SIGNED);     // lone minus
    send_byte(8'd0, rand_func());
    send_str(".5 ", KIND_REAL);
    send_str("-1.2.", KIND_REAL);
    send_str("7-", KIND_SIGNED);
    send_str("3.", KIND_UNSIGNED);
    send_str("ab ", KIND_SKIP);
    send_str("!", KIND_REAL);
    drain();

    rand_start = sent_bytes;
    while (sent_bytes < rand_start + RandBytes) begin
      send_random_token();
      if (!paused && sent_bytes >= rand_start + RandBytes / 2) begin
        drain();
        paused = 1'b1;
      end
    end
    send_byte(CH_SEP_MAX, rand_func());
    drain();
    repeat (10) @(posedge clk_i);

    $display("covered %0d bytes, %0d tokens (unsigned %0d, signed %0d, real %0d), %0d saturated",
             sent_bytes, sb.n_results, sb.n_kind[0], sb.n_kind[1], sb.n_kind[2],
             sb.n_overflow);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb_ascii_decimal_token_parser_top: PASS");
    end else begin
      $display("tb_ascii_decimal_token_parser_top: FAIL");
    end
    $finish;
  end

  initial begin
    #400us;
    $display("timeout with %0d words outstanding", sb.pending());
    $display("tb_ascii_decimal_token_parser_top: FAIL");
    $finish;
  end

endmodule

/* filelist.f */
+incdir+rtl
rtl/adtp_pkg.sv
rtl/adtp_front.sv
rtl/adtp_queue.sv
rtl/adtp_back.sv
rtl/ascii_decimal_token_parser_top.sv
bench/tb_ascii_decimal_token_parser_top.sv
